### rtl/libr_pkg.sv
// ----------------------------------------------------------------------------
// Libration correction package
// Tidal term table, CORDIC arctangent table and shared widths.
// ----------------------------------------------------------------------------
package libr_pkg;

  localparam int TableRows = 16;
  localparam int IdxW = 4;
  localparam int CordicSteps = 30;
  localparam int CordicW = 34;
  localparam int AccW = 44;

  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [63:0] HalfPiQ31 = 64'sd3373259426;

  localparam logic [31:0] AtanQ30 [CordicSteps] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFD, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
  };

  typedef logic signed [2:0] mult_t;

  typedef struct packed {
    mult_t [5:0] mult;
    logic signed [9:0] ut_sin;
    logic signed [9:0] ut_cos;
    logic signed [9:0] lod_sin;
    logic signed [9:0] lod_cos;
  } tide_row_t;

  // Angle multipliers are listed in the order Omega, D, F, l', l, GMST+pi
  // (index 0 is GMST+pi). Rows past the eleventh are zero.
  function automatic tide_row_t tide_row(input logic [IdxW-1:0] idx);
    tide_row_t r;
    r = '0;
    case (idx)
      4'd0:  r = '{'{-3'sd2, 3'sd0, -3'sd2, 3'sd0, -3'sd2, 3'sd2}, 10'sd5, -10'sd3, -10'sd3, -10'sd6};
      4'd1:  r = '{'{-3'sd2, -3'sd2, -3'sd2, 3'sd0, 3'sd0, 3'sd2}, 10'sd6, -10'sd3, -10'sd4, -10'sd7};
      4'd2:  r = '{'{-3'sd2, 3'sd0, -3'sd2, 3'sd0, -3'sd1, 3'sd2}, 10'sd35, -10'sd20, -10'sd24,
                   -10'sd41};
      4'd3:  r = '{'{-3'sd2, -3'sd2, -3'sd2, 3'sd0, 3'sd1, 3'sd2}, 10'sd7, -10'sd4, -10'sd5, -10'sd8};
      4'd4:  r = '{'{-3'sd1, 3'sd0, -3'sd2, 3'sd0, 3'sd0, 3'sd2}, -10'sd7, 10'sd4, 10'sd5, 10'sd8};
      4'd5:  r = '{'{-3'sd2, 3'sd0, -3'sd2, 3'sd0, 3'sd0, 3'sd2}, 10'sd175, -10'sd101, -10'sd122,
                   -10'sd213};
      4'd6:  r = '{'{-3'sd2, 3'sd0, -3'sd2, 3'sd0, 3'sd1, 3'sd2}, -10'sd5, 10'sd3, 10'sd3, 10'sd6};
      4'd7:  r = '{'{-3'sd2, 3'sd2, -3'sd2, -3'sd1, 3'sd0, 3'sd2}, 10'sd4, -10'sd3, -10'sd3, -10'sd6};
      4'd8:  r = '{'{-3'sd2, 3'sd2, -3'sd2, 3'sd0, 3'sd0, 3'sd2}, 10'sd76, -10'sd44, -10'sd55,
                   -10'sd96};
      4'd9:  r = '{'{3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd2}, 10'sd21, -10'sd12, -10'sd15, -10'sd26};
      4'd10: r = '{'{-3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd2}, 10'sd6, -10'sd4, -10'sd4, -10'sd8};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/libr_if.sv
// ----------------------------------------------------------------------------
// Libration correction channels
// Valid/ready channels for the angle items and the correction results.
// ----------------------------------------------------------------------------
interface libr_angles_if;
  logic valid;
  logic ready;
  logic [31:0] gmst_plus_pi;
  logic [31:0] moon_anomaly;
  logic [31:0] sun_anomaly;
  logic [31:0] moon_latitude_arg;
  logic [31:0] moon_elongation;
  logic [31:0] node_longitude;

  modport source (output valid, gmst_plus_pi, moon_anomaly, sun_anomaly,
                  moon_latitude_arg, moon_elongation, node_longitude, input ready);
  modport sink (input valid, gmst_plus_pi, moon_anomaly, sun_anomaly,
                moon_latitude_arg, moon_elongation, node_longitude, output ready);
endinterface

interface libr_corr_if;
  logic valid;
  logic ready;
  logic signed [19:0] dut1_correction;
  logic signed [22:0] dlod_correction;

  modport source (output valid, dut1_correction, dlod_correction, input ready);
  modport sink (input valid, dut1_correction, dlod_correction, output ready);
endinterface

### rtl/libration_ut1_lod_correction.sv
// ----------------------------------------------------------------------------
// Semidiurnal libration dUT1 / dLOD correction
// Sums the fixed tidal terms through one pipelined CORDIC sine/cosine unit.
// ----------------------------------------------------------------------------
// A transaction is taken only while the issuer is idle; the issuer then sends
// one tidal term per cycle into the shared sine/cosine pipeline, unless the
// result side stalls.
// A stall on the result side freezes the whole pipeline; nothing is lost.
// Reset (rst, synchronous) clears all valid bits, the term issuer and the
// result flag; data registers are not reset.
module libration_ut1_lod_correction #(
  parameter int TERM_COUNT = 11
) (
  input logic clk,
  input logic rst,
  libr_angles_if.sink angles,
  libr_corr_if.source corr
);

  localparam int IW = libr_pkg::IdxW;
  localparam int CW = libr_pkg::CordicW;
  localparam int AW = libr_pkg::AccW;
  localparam int NS = libr_pkg::CordicSteps;
  localparam logic [IW-1:0] LastIdx = IW'(TERM_COUNT - 1);

  // The whole pipeline advances together whenever the result register can
  // take a new value.
  logic en;
  assign en = !corr.valid || corr.ready;

  // ---------------- Term issuer ----------------
  // A transaction latches the six angles; one term per cycle is then issued while the result side does not stall.
  logic busy;
  logic [IW-1:0] term;
  logic [31:0] ang [6];

  assign angles.ready = !busy;

  function automatic logic [31:0] mul_small(input libr_pkg::mult_t m, input logic [31:0] a);
    logic [31:0] r;
    case (m)
      3'sd1:   r = a;
      3'sd2:   r = {a[30:0], 1'b0};
      -3'sd1:  r = -a;
      -3'sd2:  r = -{a[30:0], 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [31:0] u_next;
  always_comb begin
    libr_pkg::tide_row_t row;
    row = libr_pkg::tide_row(term);
    u_next = '0;
    for (int i = 0; i < 6; i++) begin
      u_next = u_next + mul_small(row.mult[i], ang[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      term <= '0;
    end else if (angles.valid && angles.ready) begin
      busy <= 1'b1;
      term <= '0;
    end else if (en && busy) begin
      term <= term + 1'b1;
      if (term == LastIdx) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (angles.valid && angles.ready) begin
      ang[0] <= angles.gmst_plus_pi;
      ang[1] <= angles.moon_anomaly;
      ang[2] <= angles.sun_anomaly;
      ang[3] <= angles.moon_latitude_arg;
      ang[4] <= angles.moon_elongation;
      ang[5] <= angles.node_longitude;
    end
  end

  // ---------------- Stage A: term angle ----------------
  logic a_valid, a_first, a_last;
  logic [IW-1:0] a_idx;
  logic [31:0] a_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_u <= u_next;
      a_idx <= term;
      a_first <= (term == '0);
      a_last <= (term == LastIdx);
    end
  end

  // ---------------- Stage B: quadrant split and scale to radians ----------------
  // The angle splits into the nearest quarter turn and a residual within
  // one eighth of a turn; the residual is scaled by pi/2.
  logic b_valid, b_first, b_last;
  logic [IW-1:0] b_idx;
  logic [1:0] b_q;
  logic signed [63:0] b_prod;
  logic [31:0] b_uplus;
  logic [31:0] b_r;

  assign b_uplus = a_u + 32'h2000_0000;
  assign b_r = a_u - {b_uplus[31:30], 30'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_q <= b_uplus[31:30];
      b_prod <= 64'(signed'(b_r)) * libr_pkg::HalfPiQ31;
      b_idx <= a_idx;
      b_first <= a_first;
      b_last <= a_last;
    end
  end

  // ---------------- Stage C: round residual to Q30 ----------------
  // Rounds to nearest with halves away from zero.
  logic [63:0] c_mag;
  logic [63:0] c_zmag;
  logic signed [CW-1:0] c_z;

  assign c_mag = b_prod[63] ? 64'(-b_prod) : 64'(b_prod);
  assign c_zmag = (c_mag + 64'h4000_0000) >> 31;
  assign c_z = b_prod[63] ? -CW'(c_zmag) : CW'(c_zmag);

  logic signed [CW-1:0] cx [NS+1];
  logic signed [CW-1:0] cy [NS+1];
  logic signed [CW-1:0] cz [NS+1];
  logic cv [NS+1];
  logic cfirst [NS+1];
  logic clast [NS+1];
  logic [1:0] cq [NS+1];
  logic [IW-1:0] cidx [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= libr_pkg::CordicGain;
      cy[0] <= '0;
      cz[0] <= c_z;
      cq[0] <= b_q;
      cidx[0] <= b_idx;
      cfirst[0] <= b_first;
      clast[0] <= b_last;
    end
  end

  // ---------------- CORDIC rotation stages ----------------
  // One rotation per stage; shifts are arithmetic, so they floor.
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [CW-1:0] atan;
    assign atan = CW'(signed'({2'b00, libr_pkg::AtanQ30[i]}));

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][CW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan;
        end
        cq[i+1] <= cq[i];
        cidx[i+1] <= cidx[i];
        cfirst[i+1] <= cfirst[i];
        clast[i+1] <= clast[i];
      end
    end
  end

  // ---------------- Stage D: quadrant rotation ----------------
  logic d_valid, d_first, d_last;
  logic [IW-1:0] d_idx;
  logic signed [CW-1:0] d_cos, d_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= cv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (cq[NS])
        2'd0: begin
          d_cos <= cx[NS];
          d_sin <= cy[NS];
        end
        2'd1: begin
          d_cos <= -cy[NS];
          d_sin <= cx[NS];
        end
        2'd2: begin
          d_cos <= -cx[NS];
          d_sin <= -cy[NS];
        end
        default: begin
          d_cos <= cy[NS];
          d_sin <= -cx[NS];
        end
      endcase
      d_idx <= cidx[NS];
      d_first <= cfirst[NS];
      d_last <= clast[NS];
    end
  end

  // ---------------- Stage E: coefficient products ----------------
  logic e_valid, e_first, e_last;
  logic signed [AW-1:0] e_ut_s, e_ut_c, e_lod_s, e_lod_c;
  libr_pkg::tide_row_t d_row;

  assign d_row = libr_pkg::tide_row(d_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ut_s <= AW'(d_row.ut_sin) * AW'(d_sin);
      e_ut_c <= AW'(d_row.ut_cos) * AW'(d_cos);
      e_lod_s <= AW'(d_row.lod_sin) * AW'(d_sin);
      e_lod_c <= AW'(d_row.lod_cos) * AW'(d_cos);
      e_first <= d_first;
      e_last <= d_last;
    end
  end

  // ---------------- Stage G: term sums ----------------
  logic g_valid, g_first, g_last;
  logic signed [AW-1:0] g_ut, g_lod;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_ut <= e_ut_s + e_ut_c;
      g_lod <= e_lod_s + e_lod_c;
      g_first <= e_first;
      g_last <= e_last;
    end
  end

  // ---------------- Accumulator ----------------
  logic acc_done;
  logic signed [AW-1:0] acc_ut, acc_lod;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
    end else if (en) begin
      acc_done <= g_valid && g_last;
    end
  end

  always_ff @(posedge clk) begin
    if (en && g_valid) begin
      acc_ut <= g_first ? g_ut : acc_ut + g_ut;
      acc_lod <= g_first ? g_lod : acc_lod + g_lod;
    end
  end

  // ---------------- F1: magnitude plus half divisor ----------------
  // dUT1 divides by 100 * 2^14, dLOD by 10 * 2^14.
  logic f1_valid, f1_neg_ut, f1_neg_lod;
  logic [AW-1:0] f1_m_ut, f1_m_lod;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= acc_done;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_neg_ut <= acc_ut[AW-1];
      f1_neg_lod <= acc_lod[AW-1];
      f1_m_ut <= (acc_ut[AW-1] ? AW'(-acc_ut) : AW'(acc_ut)) + AW'(819200);
      f1_m_lod <= (acc_lod[AW-1] ? AW'(-acc_lod) : AW'(acc_lod)) + AW'(81920);
    end
  end

  // ---------------- F2: reciprocal multiply ----------------
  // The 2^14 part is a shift; the decimal part uses floor(2^32 / d), which
  // gives the quotient or one less.
  logic f2_valid, f2_neg_ut, f2_neg_lod;
  logic [29:0] f2_v_ut, f2_v_lod;
  logic [63:0] f2_p_ut, f2_p_lod;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_v_ut <= f1_m_ut[43:14];
      f2_v_lod <= f1_m_lod[43:14];
      f2_p_ut <= 64'(f1_m_ut[43:14]) * 64'd42949672;
      f2_p_lod <= 64'(f1_m_lod[43:14]) * 64'd429496729;
      f2_neg_ut <= f1_neg_ut;
      f2_neg_lod <= f1_neg_lod;
    end
  end

  // ---------------- F3: correction, sign and saturation ----------------
  logic [29:0] q0_ut, q0_lod, rem_ut, rem_lod, q_ut, q_lod;
  logic signed [19:0] ut_sat;
  logic signed [22:0] lod_sat;

  always_comb begin
    q0_ut = f2_p_ut[61:32];
    q0_lod = f2_p_lod[61:32];
    rem_ut = f2_v_ut - 30'(q0_ut * 30'd100);
    rem_lod = f2_v_lod - 30'(q0_lod * 30'd10);
    q_ut = (rem_ut >= 30'd100) ? q0_ut + 30'd1 : q0_ut;
    q_lod = (rem_lod >= 30'd10) ? q0_lod + 30'd1 : q0_lod;
    if (f2_neg_ut) begin
      ut_sat = (q_ut > 30'd524288) ? -20'sd524288 : -20'(q_ut);
    end else begin
      ut_sat = (q_ut > 30'd524287) ? 20'sd524287 : 20'(q_ut);
    end
    if (f2_neg_lod) begin
      lod_sat = (q_lod > 30'd4194304) ? -23'sd4194304 : -23'(q_lod);
    end else begin
      lod_sat = (q_lod > 30'd4194303) ? 23'sd4194303 : 23'(q_lod);
    end
  end

  // ---------------- Result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      corr.valid <= 1'b0;
    end else if (en) begin
      corr.valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && f2_valid) begin
      corr.dut1_correction <= ut_sat;
      corr.dlod_correction <= lod_sat;
    end
  end

  // ---------------- Assertions ----------------
  a_term_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (32'(term) < TERM_COUNT))
    else $error("term index ran past the last tidal term");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (angles.valid && angles.ready) |=> busy)
    else $error("issuer did not start after a transaction");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(acc_ut) && $stable(acc_lod)))
    else $error("pipeline moved during an output stall");

endmodule
